// ----- rtl/photometric_normal_solver_macros.svh -----
// Assertion macros for the photometric normal solver.
// Included by the RTL files that carry concurrent checks; no dependencies.
`ifndef PHOTOMETRIC_NORMAL_SOLVER_MACROS_SVH
`define PHOTOMETRIC_NORMAL_SOLVER_MACROS_SVH
`ifndef SYNTHESIS
`define PNS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pns assertion failed");
`define PNS_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pns forbidden condition seen");
`else
`define PNS_ASSERT(name, clk, rst_n, prop)
`define PNS_NEVER(name, clk, rst_n, cond)
`endif
`endif

// ----- rtl/pns_pkg.sv -----
// Package for the photometric normal solver: widths, codes, the solve
// microprogram and the control structs of the shared wide unit. No dependencies.
`timescale 1ns / 1ps

package pns_pkg;

  localparam int MAX_LIGHTS = 16;
  localparam int POS_W      = $clog2(MAX_LIGHTS + 1);
  localparam int SUM_W      = 48;   // pixel sums
  localparam int WIDE_W     = 160;  // cofactors, determinant, numerators
  localparam int LW         = 22;   // scaled light component
  localparam int PW         = 2 * LW;
  localparam int Q_W        = 32;
  localparam int FRAC_SH    = 16;
  localparam int CNT_W      = $clog2(WIDE_W + 1);
  localparam int NSUM       = 9;
  localparam int NWIDE      = 10;
  localparam int PROG_LEN   = 24;
  localparam int STEP_W     = 5;
  localparam int MIN_OBS    = 3;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // result status codes
  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_FEW  = 3'd1;
  localparam logic [2:0] ST_SING = 3'd2;
  localparam logic [2:0] ST_ZNEG = 3'd3;
  localparam logic [2:0] ST_ZERO = 3'd4;

  // register indexes
  localparam logic CFG_LOW  = 1'b0;
  localparam logic CFG_HIGH = 1'b1;

  // shared unit operations
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  // sum slots
  localparam logic [3:0] A00 = 4'd0;
  localparam logic [3:0] A01 = 4'd1;
  localparam logic [3:0] A02 = 4'd2;
  localparam logic [3:0] A11 = 4'd3;
  localparam logic [3:0] A12 = 4'd4;
  localparam logic [3:0] A22 = 4'd5;
  localparam logic [3:0] B0  = 4'd6;
  localparam logic [3:0] B1  = 4'd7;
  localparam logic [3:0] B2  = 4'd8;

  // wide register slots
  localparam logic [3:0] W_C00 = 4'd0;
  localparam logic [3:0] W_C01 = 4'd1;
  localparam logic [3:0] W_C02 = 4'd2;
  localparam logic [3:0] W_C11 = 4'd3;
  localparam logic [3:0] W_C12 = 4'd4;
  localparam logic [3:0] W_C22 = 4'd5;
  localparam logic [3:0] W_DET = 4'd6;
  localparam logic [3:0] W_N0  = 4'd7;
  localparam logic [3:0] W_N1  = 4'd8;
  localparam logic [3:0] W_N2  = 4'd9;

  typedef struct packed {
    logic start;
    logic op;
  } pns_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pns_sts_t;

  // one multiply-accumulate step of the solve
  typedef struct packed {
    logic       a_wide;  // multiplicand from wide slots, else from sums
    logic [3:0] a_idx;
    logic [3:0] b_idx;   // multiplier, always a sum
    logic       sub;
    logic       first;   // start a fresh accumulation
    logic       wr;      // store the accumulation
    logic [3:0] dst;
  } pns_uop_t;

  function automatic pns_uop_t pns_prog(input logic [STEP_W-1:0] step);
    pns_uop_t u;
    u = '0;
    case (step)
      5'd0:  u = '{1'b0, A11,   A22, 1'b0, 1'b1, 1'b0, W_C00};
      5'd1:  u = '{1'b0, A12,   A12, 1'b1, 1'b0, 1'b1, W_C00};
      5'd2:  u = '{1'b0, A02,   A12, 1'b0, 1'b1, 1'b0, W_C01};
      5'd3:  u = '{1'b0, A01,   A22, 1'b1, 1'b0, 1'b1, W_C01};
      5'd4:  u = '{1'b0, A01,   A12, 1'b0, 1'b1, 1'b0, W_C02};
      5'd5:  u = '{1'b0, A11,   A02, 1'b1, 1'b0, 1'b1, W_C02};
      5'd6:  u = '{1'b0, A00,   A22, 1'b0, 1'b1, 1'b0, W_C11};
      5'd7:  u = '{1'b0, A02,   A02, 1'b1, 1'b0, 1'b1, W_C11};
      5'd8:  u = '{1'b0, A01,   A02, 1'b0, 1'b1, 1'b0, W_C12};
      5'd9:  u = '{1'b0, A00,   A12, 1'b1, 1'b0, 1'b1, W_C12};
      5'd10: u = '{1'b0, A00,   A11, 1'b0, 1'b1, 1'b0, W_C22};
      5'd11: u = '{1'b0, A01,   A01, 1'b1, 1'b0, 1'b1, W_C22};
      5'd12: u = '{1'b1, W_C00, A00, 1'b0, 1'b1, 1'b0, W_DET};
      5'd13: u = '{1'b1, W_C01, A01, 1'b0, 1'b0, 1'b0, W_DET};
      5'd14: u = '{1'b1, W_C02, A02, 1'b0, 1'b0, 1'b1, W_DET};
      5'd15: u = '{1'b1, W_C00, B0,  1'b0, 1'b1, 1'b0, W_N0};
      5'd16: u = '{1'b1, W_C01, B1,  1'b0, 1'b0, 1'b0, W_N0};
      5'd17: u = '{1'b1, W_C02, B2,  1'b0, 1'b0, 1'b1, W_N0};
      5'd18: u = '{1'b1, W_C01, B0,  1'b0, 1'b1, 1'b0, W_N1};
      5'd19: u = '{1'b1, W_C11, B1,  1'b0, 1'b0, 1'b0, W_N1};
      5'd20: u = '{1'b1, W_C12, B2,  1'b0, 1'b0, 1'b1, W_N1};
      5'd21: u = '{1'b1, W_C02, B0,  1'b0, 1'b1, 1'b0, W_N2};
      5'd22: u = '{1'b1, W_C12, B1,  1'b0, 1'b0, 1'b0, W_N2};
      5'd23: u = '{1'b1, W_C22, B2,  1'b0, 1'b0, 1'b1, W_N2};
      default: u = '0;
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/pns_wide_unit.sv -----
// Shared wide arithmetic unit: shift-add multiply and restoring divide.
// Depends on pns_pkg.
`timescale 1ns / 1ps

module pns_wide_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pns_pkg::pns_ctl_t                   ctl_i,
  input  logic signed [pns_pkg::WIDE_W-1:0]   opa_i,
  input  logic signed [pns_pkg::WIDE_W-1:0]   opb_i,
  output pns_pkg::pns_sts_t                   sts_o,
  output logic signed [pns_pkg::WIDE_W-1:0]   prod_o,
  output logic signed [pns_pkg::Q_W-1:0]      quot_o
);

  logic                              run_q, fin_q, done_q;
  logic [pns_pkg::CNT_W-1:0]         cnt_q;
  logic                              op_q, neg_q, big_q;
  logic [pns_pkg::WIDE_W-1:0]        acc_q, x_q, y_q;
  logic [pns_pkg::Q_W-1:0]           q_q;
  logic signed [pns_pkg::WIDE_W-1:0] prod_q;
  logic signed [pns_pkg::Q_W-1:0]    quot_q;

  logic [pns_pkg::WIDE_W-1:0] abs_a, abs_b, rem2, add_s;
  logic [pns_pkg::WIDE_W:0]   diff;
  logic                       ge, last_it;

  always_comb begin
    abs_a   = opa_i[pns_pkg::WIDE_W-1] ? -opa_i : opa_i;
    abs_b   = opb_i[pns_pkg::WIDE_W-1] ? -opb_i : opb_i;
    rem2    = {acc_q[pns_pkg::WIDE_W-2:0], x_q[pns_pkg::WIDE_W-1]};
    diff    = {1'b0, rem2} - {1'b0, y_q};
    ge      = !diff[pns_pkg::WIDE_W];
    add_s   = acc_q + x_q;
    last_it = (cnt_q == pns_pkg::CNT_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= run_q && last_it;
      if (ctl_i.start) begin
        run_q <= 1'b1;
        cnt_q <= (ctl_i.op == pns_pkg::OP_MUL) ? pns_pkg::CNT_W'(pns_pkg::SUM_W)
                                                : pns_pkg::CNT_W'(pns_pkg::WIDE_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - pns_pkg::CNT_W'(1);
        if (last_it) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      op_q  <= ctl_i.op;
      neg_q <= opa_i[pns_pkg::WIDE_W-1] ^ opb_i[pns_pkg::WIDE_W-1];
      acc_q <= '0;
      x_q   <= (ctl_i.op == pns_pkg::OP_MUL) ? abs_a : (abs_a << pns_pkg::FRAC_SH);
      y_q   <= abs_b;
      q_q   <= '0;
      big_q <= 1'b0;
    end else if (run_q) begin
      x_q <= x_q << 1;
      if (op_q == pns_pkg::OP_MUL) begin
        if (y_q[0]) begin
          acc_q <= add_s;
        end
        y_q <= y_q >> 1;
      end else begin
        acc_q <= ge ? diff[pns_pkg::WIDE_W-1:0] : rem2;
        q_q   <= {q_q[pns_pkg::Q_W-2:0], ge};
        big_q <= big_q | q_q[pns_pkg::Q_W-1];
      end
    end
    if (fin_q) begin
      prod_q <= neg_q ? -acc_q : acc_q;
      if (big_q || q_q[pns_pkg::Q_W-1]) begin
        quot_q <= neg_q ? pns_pkg::Q_MIN : pns_pkg::Q_MAX;
      end else begin
        quot_q <= neg_q ? -q_q : q_q;
      end
    end
  end

  assign sts_o.busy = run_q || fin_q;
  assign sts_o.done = done_q;
  assign prod_o     = prod_q;
  assign quot_o     = quot_q;

endmodule

// ----- rtl/photometric_normal_solver.sv -----
// Photometric normal solver top level: per-light accumulation and solve sequencer.
// Depends on pns_pkg, pns_wide_unit and photometric_normal_solver_macros.svh.
// A used light runs twelve products through one 22x22 multiplier, an unused light none.
//   On the last light the solve runs 24 shift-add multiplies and 3 restoring divides
//   in the shared wide unit.
// Throughput: one word at a time; in_stall_o is high from acceptance until the next idle.
// Reset: asynchronous, thresholds to 655 and 65535, pixel sums and counters to zero.
`timescale 1ns / 1ps
`include "photometric_normal_solver_macros.svh"

module photometric_normal_solver (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  // light words in
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [15:0]         intensity_i,
  input  logic signed [15:0]  light_x_i,
  input  logic signed [15:0]  light_y_i,
  input  logic signed [15:0]  light_z_i,
  input  logic [15:0]         gain_i,
  input  logic                saturated_i,
  input  logic signed [4:0]   excluded_light_i,
  input  logic                last_i,
  // result words out
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          status_o,
  output logic [4:0]          observations_o,
  output logic signed [31:0]  normal_x_o,
  output logic signed [31:0]  normal_y_o,
  output logic signed [31:0]  normal_z_o
);

  localparam int SUM_W  = pns_pkg::SUM_W;
  localparam int WIDE_W = pns_pkg::WIDE_W;
  localparam int LW     = pns_pkg::LW;
  localparam int PW     = pns_pkg::PW;
  localparam int POS_W  = pns_pkg::POS_W;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MAC   = 4'd1;   // light accumulation
  localparam logic [3:0] S_PXEND = 4'd2;   // end of a light, maybe start the solve
  localparam logic [3:0] S_LDA   = 4'd3;   // fetch multiplicand
  localparam logic [3:0] S_LDB   = 4'd4;   // fetch multiplier
  localparam logic [3:0] S_GO    = 4'd5;
  localparam logic [3:0] S_WAIT  = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;   // accumulate product, store
  localparam logic [3:0] S_CHKZ  = 4'd8;   // sign of z against determinant
  localparam logic [3:0] S_DLD   = 4'd9;
  localparam logic [3:0] S_DGO   = 4'd10;
  localparam logic [3:0] S_DWAIT = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;

  localparam logic [3:0] MAC_LAST   = 4'd13;
  localparam logic [3:0] MAC_L0     = 4'd1;
  localparam logic [3:0] MAC_L1     = 4'd2;
  localparam logic [3:0] MAC_L2     = 4'd3;
  localparam logic [3:0] MAC_SUM0   = 4'd5;
  localparam logic [1:0] DIV_LAST   = 2'd2;
  localparam logic [pns_pkg::STEP_W-1:0] STEP_LAST = pns_pkg::STEP_W'(pns_pkg::PROG_LEN - 1);

  // control
  logic [3:0]                  state_q, state_d;
  logic [3:0]                  cnt_q;
  logic [pns_pkg::STEP_W-1:0]  step_q;
  logic [1:0]                  div_q;
  logic [POS_W-1:0]            pos_q, used_q;
  logic [15:0]                 low_q, high_q;
  logic signed [SUM_W-1:0]     sum_q [pns_pkg::NSUM];
  logic                        out_valid_q;

  // payload
  logic [15:0]                 int_q, gain_q;
  logic signed [15:0]          dir_q [3];
  logic                        use_q, last_q;
  logic signed [PW-1:0]        preg_q;
  logic signed [LW-1:0]        l_q [3];
  logic signed [WIDE_W-1:0]    opa_q, opb_q, acc_q;
  logic signed [WIDE_W-1:0]    wide_q [pns_pkg::NWIDE];
  logic signed [31:0]          nrm_q [3];
  logic [2:0]                  st_q;
  logic [2:0]                  ost_q;
  logic [4:0]                  oobs_q;
  logic signed [31:0]          onx_q, ony_q, onz_q;

  logic                        accept, pos_ok, excl_hit, use_d, emit_go, det_zero;
  logic signed [LW-1:0]        mul_a, mul_b;
  logic signed [PW-1:0]        mul_p, adj;
  logic [3:0]                  sidx, rd_sidx, wrd_idx;
  logic signed [SUM_W-1:0]     sum_rd;
  logic signed [WIDE_W-1:0]    wide_rd, acc_base, acc_new;
  pns_pkg::pns_uop_t           uop;
  pns_pkg::pns_ctl_t           unit_ctl;
  pns_pkg::pns_sts_t           unit_sts;
  logic signed [WIDE_W-1:0]    unit_prod;
  logic signed [31:0]          unit_quot;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign emit_go    = !out_valid_q || !out_stall_i;
  assign uop        = pns_pkg::pns_prog(step_q);

  // light selection
  always_comb begin
    pos_ok   = (pos_q < POS_W'(pns_pkg::MAX_LIGHTS));
    excl_hit = !excluded_light_i[4] && (8'(pos_q) == 8'(excluded_light_i[3:0]));
    use_d    = pos_ok && !excl_hit && !saturated_i &&
               (intensity_i > low_q) && (intensity_i < high_q);
  end

  // per-light multiplier: gain * dir first, then the nine sum terms
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cnt_q)
      4'd0:  begin mul_a = LW'(signed'({1'b0, gain_q})); mul_b = LW'(dir_q[0]); end
      4'd1:  begin mul_a = LW'(signed'({1'b0, gain_q})); mul_b = LW'(dir_q[1]); end
      4'd2:  begin mul_a = LW'(signed'({1'b0, gain_q})); mul_b = LW'(dir_q[2]); end
      4'd4:  begin mul_a = l_q[0]; mul_b = l_q[0]; end
      4'd5:  begin mul_a = l_q[0]; mul_b = l_q[1]; end
      4'd6:  begin mul_a = l_q[0]; mul_b = l_q[2]; end
      4'd7:  begin mul_a = l_q[1]; mul_b = l_q[1]; end
      4'd8:  begin mul_a = l_q[1]; mul_b = l_q[2]; end
      4'd9:  begin mul_a = l_q[2]; mul_b = l_q[2]; end
      4'd10: begin mul_a = l_q[0]; mul_b = LW'(signed'({1'b0, int_q})); end
      4'd11: begin mul_a = l_q[1]; mul_b = LW'(signed'({1'b0, int_q})); end
      4'd12: begin mul_a = l_q[2]; mul_b = LW'(signed'({1'b0, int_q})); end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
    // divide by 1024 truncating toward zero
    adj   = preg_q + {{(PW-10){1'b0}}, {10{preg_q[PW-1]}}};
  end

  // single read port on the sums, one indexed port on the wide slots (determinant and N2 read directly)
  always_comb begin
    sidx = cnt_q - MAC_SUM0;
    if (state_q == S_MAC) begin
      rd_sidx = sidx;
    end else if (state_q == S_LDA) begin
      rd_sidx = uop.a_idx;
    end else begin
      rd_sidx = uop.b_idx;
    end
    sum_rd  = sum_q[rd_sidx];
    wrd_idx = (state_q == S_DLD) ? (pns_pkg::W_N0 + 4'(div_q)) : uop.a_idx;
    wide_rd = wide_q[wrd_idx];
    acc_base = uop.first ? '0 : acc_q;
    acc_new  = uop.sub ? (acc_base - unit_prod) : (acc_base + unit_prod);
    det_zero = uop.wr && (uop.dst == pns_pkg::W_DET) && (acc_new == '0);
  end

  always_comb begin
    unit_ctl.start = (state_q == S_GO) || (state_q == S_DGO);
    unit_ctl.op    = (state_q == S_DGO) ? pns_pkg::OP_DIV : pns_pkg::OP_MUL;
  end

  pns_wide_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (unit_ctl),
    .opa_i  (opa_q),
    .opb_i  (opb_q),
    .sts_o  (unit_sts),
    .prod_o (unit_prod),
    .quot_o (unit_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = use_d ? S_MAC : S_PXEND;
      S_MAC:   if (cnt_q == MAC_LAST) state_d = S_PXEND;
      S_PXEND: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (used_q < POS_W'(pns_pkg::MIN_OBS)) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_LDA;
        end
      end
      S_LDA:   state_d = S_LDB;
      S_LDB:   state_d = S_GO;
      S_GO:    state_d = S_WAIT;
      S_WAIT:  if (unit_sts.done) state_d = S_ACC;
      S_ACC: begin
        if (det_zero) begin
          state_d = S_EMIT;
        end else if (step_q == STEP_LAST) begin
          state_d = S_CHKZ;
        end else begin
          state_d = S_LDA;
        end
      end
      S_CHKZ: begin
        if (wide_q[pns_pkg::W_N2] == '0 ||
            wide_q[pns_pkg::W_N2][WIDE_W-1] != wide_q[pns_pkg::W_DET][WIDE_W-1]) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_DLD;
        end
      end
      S_DLD:   state_d = S_DGO;
      S_DGO:   state_d = S_DWAIT;
      S_DWAIT: if (unit_sts.done) state_d = (div_q == DIV_LAST) ? S_DONE : S_DLD;
      S_DONE:  state_d = S_EMIT;
      S_EMIT:  if (emit_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      step_q      <= '0;
      div_q       <= '0;
      pos_q       <= '0;
      used_q      <= '0;
      low_q       <= 16'd655;
      high_q      <= 16'hFFFF;
      out_valid_q <= 1'b0;
      for (int i = 0; i < pns_pkg::NSUM; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pns_pkg::CFG_LOW:  low_q  <= cfg_data_i;
          pns_pkg::CFG_HIGH: high_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        cnt_q <= '0;
        if (pos_ok) pos_q <= pos_q + POS_W'(1);
        if (use_d) used_q <= used_q + POS_W'(1);
      end
      if (state_q == S_MAC) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q >= MAC_SUM0) begin
          sum_q[sidx] <= sum_rd + {{(SUM_W-PW){preg_q[PW-1]}}, preg_q};
        end
      end
      if (state_q == S_PXEND) step_q <= '0;
      if (state_q == S_ACC) step_q <= step_q + pns_pkg::STEP_W'(1);
      if (state_q == S_CHKZ) div_q <= '0;
      if (state_q == S_DWAIT && unit_sts.done) div_q <= div_q + 2'd1;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == S_EMIT && emit_go) begin
        out_valid_q <= 1'b1;
        pos_q       <= '0;
        used_q      <= '0;
        for (int i = 0; i < pns_pkg::NSUM; i++) begin
          sum_q[i] <= '0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      int_q    <= intensity_i;
      gain_q   <= gain_i;
      dir_q[0] <= light_x_i;
      dir_q[1] <= light_y_i;
      dir_q[2] <= light_z_i;
      use_q    <= use_d;
      last_q   <= last_i;
    end
    if (state_q == S_MAC) begin
      preg_q <= mul_p;
      if (cnt_q == MAC_L0) l_q[0] <= adj[LW+9:10];
      if (cnt_q == MAC_L1) l_q[1] <= adj[LW+9:10];
      if (cnt_q == MAC_L2) l_q[2] <= adj[LW+9:10];
    end
    if (state_q == S_PXEND) st_q <= pns_pkg::ST_FEW;
    if (state_q == S_LDA) begin
      opa_q <= uop.a_wide ? wide_rd : {{(WIDE_W-SUM_W){sum_rd[SUM_W-1]}}, sum_rd};
    end
    if (state_q == S_LDB) begin
      opb_q <= {{(WIDE_W-SUM_W){sum_rd[SUM_W-1]}}, sum_rd};
    end
    if (state_q == S_ACC) begin
      acc_q <= acc_new;
      if (uop.wr) wide_q[uop.dst] <= acc_new;
      if (det_zero) st_q <= pns_pkg::ST_SING;
    end
    if (state_q == S_CHKZ) st_q <= pns_pkg::ST_ZNEG;
    if (state_q == S_DLD) begin
      opa_q <= wide_rd;
      opb_q <= wide_q[pns_pkg::W_DET];
    end
    if (state_q == S_DWAIT && unit_sts.done) nrm_q[div_q] <= unit_quot;
    if (state_q == S_DONE) begin
      st_q <= (nrm_q[0] == '0 && nrm_q[1] == '0 && nrm_q[2] == '0) ?
              pns_pkg::ST_ZERO : pns_pkg::ST_OK;
    end
    if (state_q == S_EMIT && emit_go) begin
      ost_q  <= st_q;
      oobs_q <= 5'(used_q);
      onx_q  <= (st_q == pns_pkg::ST_OK) ? nrm_q[0] : '0;
      ony_q  <= (st_q == pns_pkg::ST_OK) ? nrm_q[1] : '0;
      onz_q  <= (st_q == pns_pkg::ST_OK) ? nrm_q[2] : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = ost_q;
  assign observations_o = oobs_q;
  assign normal_x_o     = onx_q;
  assign normal_y_o     = ony_q;
  assign normal_z_o     = onz_q;

  // a used light always advances the position as well
  `PNS_NEVER(a_used_le_pos, clk_i, rst_ni, (used_q > pos_q) || (use_q && !pos_ok && state_q == S_MAC && pos_q == '0))
  // rejected words carry a zero normal
  `PNS_ASSERT(a_reject_zero, clk_i, rst_ni, (out_valid_o && status_o != pns_pkg::ST_OK) |-> (normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0))
  // emitting a word clears the pixel and returns to idle
  `PNS_ASSERT(a_emit_clears, clk_i, rst_ni, (state_q == S_EMIT && emit_go) |=> (used_q == '0 && pos_q == '0 && state_q == S_IDLE))
  // waiting on the shared unit only while it has work in hand
  `PNS_ASSERT(a_wait_unit, clk_i, rst_ni, (state_q == S_WAIT || state_q == S_DWAIT) |-> (unit_sts.busy || unit_sts.done))

endmodule

// ----- tb/tb_photometric_normal_solver.sv -----
// Self-checking testbench for photometric_normal_solver: directed pixels, then random
// pixels under several threshold settings, checked against typed table results or an
// exact-integer predictor. Depends on pns_pkg and the solver RTL only.
`timescale 1ns / 1ps

module tb_photometric_normal_solver;

  localparam int  RUN_LIMIT = 3000000;  // cycles
  localparam int  HOLD_LEN  = 3000;     // long output hold-off, longer than one solve
  localparam int  SETTLE    = 50;       // idle cycles before a threshold write

  typedef logic signed [255:0] wide_t;  // room for cofactor * sum * 2^16

  typedef struct {
    logic [15:0]        intensity;
    logic signed [15:0] lx, ly, lz;
    logic [15:0]        gain;
    logic               sat;
    logic signed [4:0]  excl;
    logic               last;
  } word_t;

  typedef struct {
    logic [2:0]         status;
    logic [4:0]         obs;
    logic signed [31:0] nx, ny, nz;
  } res_t;

  // one row of the directed table: a threshold write or a light word
  typedef struct {
    bit          cw;
    logic [15:0] clo, chi;
    word_t       w;
    bit          typed;   // expected result typed in the row
    res_t        r;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [0:0]         cfg_idx_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [15:0]        intensity_i = '0;
  logic signed [15:0] light_x_i = '0, light_y_i = '0, light_z_i = '0;
  logic [15:0]        gain_i = '0;
  logic               saturated_i = 1'b0;
  logic signed [4:0]  excluded_light_i = '0;
  logic               last_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         status_o;
  logic [4:0]         observations_o;
  logic signed [31:0] normal_x_o, normal_y_o, normal_z_o;

  photometric_normal_solver DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: thresholds, pixel sums and counters
  // ---------------------------------------------------------------------------
  logic [15:0]        thr_lo = 16'd655, thr_hi = 16'd65535;
  logic signed [63:0] mat_acc [6];
  logic signed [63:0] vec_acc [3];
  int                 used_lights, light_pos;
  res_t               normal_q [$];   // expected results, oldest first
  row_t               tab [$];        // directed stimulus
  int                 mismatches = 0;
  longint             cycles = 0;
  bit                 hold_req = 1'b0;

  function automatic void queue_result(res_t r);
    normal_q = {normal_q, r};
  endfunction

  function automatic void add_row(row_t r);
    tab = {tab, r};
  endfunction

  function automatic void clear_pixel_sums();
    for (int i = 0; i < 6; i++) mat_acc[i] = '0;
    for (int i = 0; i < 3; i++) vec_acc[i] = '0;
    used_lights = 0;
    light_pos   = 0;
  endfunction

  // trunc(n * 2^16 / d), saturated to Q16.16
  function automatic logic signed [31:0] q16_div(wide_t n, wide_t d);
    wide_t q;
    q = (n <<< 16) / d;
    if (q > wide_t'(pns_pkg::Q_MAX)) return pns_pkg::Q_MAX;
    if (q < wide_t'(pns_pkg::Q_MIN)) return pns_pkg::Q_MIN;
    return q[31:0];
  endfunction

  function automatic res_t solve_normal();
    res_t  r;
    wide_t a00, a01, a02, a11, a12, a22, b0, b1, b2;
    wide_t c00, c01, c02, c11, c12, c22, det, n0, n1, n2;
    r = '{default: '0};
    r.obs = used_lights[4:0];
    a00 = mat_acc[0]; a01 = mat_acc[1]; a02 = mat_acc[2];
    a11 = mat_acc[3]; a12 = mat_acc[4]; a22 = mat_acc[5];
    b0 = vec_acc[0]; b1 = vec_acc[1]; b2 = vec_acc[2];
    if (used_lights < pns_pkg::MIN_OBS) begin
      r.status = pns_pkg::ST_FEW;
      return r;
    end
    c00 = a11 * a22 - a12 * a12;
    c01 = a02 * a12 - a01 * a22;
    c02 = a01 * a12 - a11 * a02;
    c11 = a00 * a22 - a02 * a02;
    c12 = a01 * a02 - a00 * a12;
    c22 = a00 * a11 - a01 * a01;
    det = a00 * c00 + a01 * c01 + a02 * c02;
    if (det == 0) begin
      r.status = pns_pkg::ST_SING;
      return r;
    end
    n0 = c00 * b0 + c01 * b1 + c02 * b2;
    n1 = c01 * b0 + c11 * b1 + c12 * b2;
    n2 = c02 * b0 + c12 * b1 + c22 * b2;
    // z must have the sign of a positive quotient
    if (n2 == 0 || ((n2 < 0) != (det < 0))) begin
      r.status = pns_pkg::ST_ZNEG;
      return r;
    end
    r.nx = q16_div(n0, det);
    r.ny = q16_div(n1, det);
    r.nz = q16_div(n2, det);
    if (r.nx == 0 && r.ny == 0 && r.nz == 0) begin
      r.nx = '0; r.ny = '0; r.nz = '0;
      r.status = pns_pkg::ST_ZERO;
      return r;
    end
    r.status = pns_pkg::ST_OK;
    return r;
  endfunction

  // takes one accepted word; returns 1 with the result when the pixel ends
  function automatic bit accumulate_light(word_t w, output res_t r);
    longint l [3];
    longint g;
    g = longint'(w.gain);
    r = '{default: '0};
    if (light_pos < pns_pkg::MAX_LIGHTS) begin
      if (light_pos != int'(w.excl) && !w.sat && w.intensity > thr_lo &&
          w.intensity < thr_hi) begin
        l[0] = (g * longint'(w.lx)) / 1024;
        l[1] = (g * longint'(w.ly)) / 1024;
        l[2] = (g * longint'(w.lz)) / 1024;
        mat_acc[0] += l[0] * l[0];
        mat_acc[1] += l[0] * l[1];
        mat_acc[2] += l[0] * l[2];
        mat_acc[3] += l[1] * l[1];
        mat_acc[4] += l[1] * l[2];
        mat_acc[5] += l[2] * l[2];
        for (int i = 0; i < 3; i++) vec_acc[i] += l[i] * longint'(w.intensity);
        used_lights++;
      end
      light_pos++;
    end
    if (!w.last) return 1'b0;
    r = solve_normal();
    clear_pixel_sums();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of words with random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_light(word_t w, bit typed, res_t typed_r);
    int   gap;
    res_t r;
    @(negedge clk_i);
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 9) > 2) gap = $urandom_range(1, 30);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    intensity_i      <= w.intensity;
    light_x_i        <= w.lx;
    light_y_i        <= w.ly;
    light_z_i        <= w.lz;
    gain_i           <= w.gain;
    saturated_i      <= w.sat;
    excluded_light_i <= w.excl;
    last_i           <= w.last;
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (accumulate_light(w, r)) queue_result(typed ? typed_r : r);
  endtask

  // drop valid and wait for every expected result
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (normal_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_thresholds(logic [15:0] lo, logic [15:0] hi);
    drain();
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= pns_pkg::CFG_LOW;
    cfg_data_i <= lo;
    @(negedge clk_i);
    cfg_idx_i  <= pns_pkg::CFG_HIGH;
    cfg_data_i <= hi;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    thr_lo = lo;
    thr_hi = hi;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern of its own, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_LEN - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(64, 512);
        end
        left--;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (normal_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word, status %0d", status_o);
      end else begin
        e = normal_q.pop_front();
        if (status_o !== e.status || observations_o !== e.obs || normal_x_o !== e.nx ||
            normal_y_o !== e.ny || normal_z_o !== e.nz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d (%0d,%0d,%0d) got %0d/%0d (%0d,%0d,%0d)",
                     e.status, e.obs, e.nx, e.ny, e.nz, status_o, observations_o,
                     normal_x_o, normal_y_o, normal_z_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table helpers and random pixel generator
  // ---------------------------------------------------------------------------
  function automatic row_t lt(int i, int x, int y, int z, int g, bit s, int e, bit l);
    row_t r;
    r = '{default: '0};
    r.w.intensity = 16'(i); r.w.lx = 16'(x); r.w.ly = 16'(y); r.w.lz = 16'(z);
    r.w.gain = 16'(g); r.w.sat = s; r.w.excl = 5'(e); r.w.last = l;
    return r;
  endfunction

  function automatic row_t chk(row_t r, logic [2:0] st, int obs, logic signed [31:0] x,
                               logic signed [31:0] y, logic signed [31:0] z);
    r.typed = 1'b1;
    r.r.status = st; r.r.obs = 5'(obs); r.r.nx = x; r.r.ny = y; r.r.nz = z;
    return r;
  endfunction

  function automatic row_t cfg_row(int lo, int hi);
    row_t r;
    r = '{default: '0};
    r.cw = 1'b1; r.clo = 16'(lo); r.chi = 16'(hi);
    return r;
  endfunction

  task automatic random_pixel(inout int count);
    int    n, sel;
    word_t w;
    res_t  dummy;
    sel = $urandom_range(0, 19);
    if (sel == 0)      n = $urandom_range(1, 2);
    else if (sel == 1) n = $urandom_range(16, 18);   // at and past the light limit
    else               n = $urandom_range(3, 8);
    dummy = '{default: '0};
    for (int k = 0; k < n; k++) begin
      w.lx = 16'($urandom_range(0, 32768) - 16384);
      w.ly = 16'($urandom_range(0, 32768) - 16384);
      w.lz = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 32768) - 16384)
                                         : 16'($urandom_range(0, 16384));
      w.gain = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(2048, 8192))
                                          : 16'($urandom_range(0, 65535));
      if (thr_hi > thr_lo + 1 && $urandom_range(0, 9) != 0)
        w.intensity = 16'($urandom_range(thr_lo + 1, thr_hi - 1));
      else
        w.intensity = 16'($urandom_range(0, 65535));
      w.sat  = ($urandom_range(0, 15) == 0);
      w.excl = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 15)) : 5'(-1);
      w.last = (k == n - 1);
      // occasional broken pixel: a word that never ends it
      if (w.last && $urandom_range(0, 49) == 0) w.last = 1'b0;
      send_light(w, 1'b0, dummy);
      count++;
    end
    if (!w.last) begin
      w.last = 1'b1;
      send_light(w, 1'b0, dummy);
      count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [15:0] set_lo [5];
    logic [15:0] set_hi [5];
    int          quota [5];
    int          count;

    clear_pixel_sums();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // axis-aligned lights, unit gain: the normal equals the intensities
    add_row(lt(1000, 16384, 0, 0, 4096, 0, -1, 0));
    add_row(lt(2000, 0, 16384, 0, 4096, 0, -1, 0));
    add_row(chk(lt(3000, 0, 0, 16384, 4096, 0, -1, 1), pns_pkg::ST_OK, 3, 1000, 2000, 3000));
    // two observations only
    add_row(lt(5000, 16384, 0, 0, 4096, 0, -1, 0));
    add_row(chk(lt(6000, 0, 16384, 0, 4096, 0, -1, 1), pns_pkg::ST_FEW, 2, 0, 0, 0));
    // identical directions: singular
    add_row(lt(1000, 16384, 0, 0, 4096, 0, -1, 0));
    add_row(lt(1000, 16384, 0, 0, 4096, 0, -1, 0));
    add_row(chk(lt(1000, 16384, 0, 0, 4096, 0, -1, 1), pns_pkg::ST_SING, 3, 0, 0, 0));
    // light from below: z negative
    add_row(lt(1000, 16384, 0, 0, 4096, 0, -1, 0));
    add_row(lt(2000, 0, 16384, 0, 4096, 0, -1, 0));
    add_row(chk(lt(3000, 0, 0, -16384, 4096, 0, -1, 1), pns_pkg::ST_ZNEG, 3, 0, 0, 0));
    // saturated, held out, at low threshold, at high threshold, then three used
    add_row(lt(9000, 16384, 0, 0, 4096, 1, 1, 0));
    add_row(lt(9000, 0, 16384, 0, 4096, 0, 1, 0));
    add_row(lt(655, 0, 0, 16384, 4096, 0, 1, 0));
    add_row(lt(65535, 0, 0, 16384, 4096, 0, 1, 0));
    add_row(lt(1000, 16384, 0, 0, 4096, 0, 1, 0));
    add_row(lt(2000, 0, 16384, 0, 4096, 0, 1, 0));
    add_row(chk(lt(3000, 0, 0, 16384, 4096, 0, 1, 1), pns_pkg::ST_OK, 3, 1000, 2000, 3000));
    // tiny gain: outputs clip at both ends of Q16.16
    add_row(lt(65534, 1024, 0, 0, 1, 0, -1, 0));
    add_row(lt(40000, 0, -1024, 0, 1, 0, 15, 0));
    add_row(chk(lt(700, 0, 0, 1024, 1, 0, -1, 1), pns_pkg::ST_OK, 3,
                pns_pkg::Q_MAX, pns_pkg::Q_MIN, 45875200));
    // full gain, full-scale directions
    add_row(lt(60000, -16384, 16384, 16384, 65535, 0, -1, 0));
    add_row(lt(1234, 16384, -16384, 16384, 65535, 0, -1, 0));
    add_row(lt(33333, 16384, 16384, 16384, 65535, 0, -1, 1));
    // open window, huge scaled light, intensity 1: everything rounds to zero
    add_row(cfg_row(0, 65535));
    add_row(lt(1, 16384, 0, 0, 65535, 0, -1, 0));
    add_row(lt(1, 0, 16384, 0, 65535, 0, -1, 0));
    add_row(chk(lt(1, 0, 0, 16384, 65535, 0, -1, 1), pns_pkg::ST_ZERO, 3, 0, 0, 0));

    foreach (tab[i]) begin
      if (tab[i].cw) write_thresholds(tab[i].clo, tab[i].chi);
      else           send_light(tab[i].w, tab[i].typed, tab[i].r);
    end

    // random phases; the empty windows only ever yield the too-few status
    set_lo = '{16'd0, 16'd655, 16'd65535, 16'($urandom_range(0, 20000)), 16'd30000};
    set_hi = '{16'd65535, 16'd65535, 16'd0, 16'($urandom_range(40000, 65535)), 16'd30000};
    quota  = '{220, 240, 50, 240, 40};
    for (int p = 0; p < 5; p++) begin
      write_thresholds(set_lo[p], set_hi[p]);
      count = 0;
      while (count < quota[p]) begin
        if (p == 1 && count > 80 && count < 90) hold_req = 1'b1;   // block fills up
        if (p == 3 && count > 100 && count < 110) drain();         // sender waits it out
        random_pixel(count);
      end
    end
    write_thresholds(16'd655, 16'd65535);
    count = 0;
    while (count < 30) random_pixel(count);

    drain();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else                 $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- photometric_normal_solver.f -----
+incdir+rtl
rtl/pns_pkg.sv
rtl/pns_wide_unit.sv
rtl/photometric_normal_solver.sv
tb/tb_photometric_normal_solver.sv
